[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while reset is released.
`define QDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qdc assertion failed");

// Check that a condition on one edge leads to a consequence on the next edge.
`define QDC_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("qdc assertion failed on the following cycle");

`endif

[rtl/core/qdc_pkg.sv]
`timescale 1ns / 1ps

package qdc_pkg;

    localparam int POS_W   = 32;
    localparam int STEPS_W = 8;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 8'd1;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_SAMPLE = 2'd0;
    localparam func_t FUNC_LOAD   = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    // Movement phase and last completed direction share one encoding.
    typedef enum logic [1:0] {
        PH_STILL = 2'd0,
        PH_CW    = 2'd1,
        PH_ACW   = 2'd2
    } phase_t;

    typedef struct packed {
        func_t                    func;
        logic                     chan_a;
        logic                     chan_b;
        logic signed [POS_W-1:0]  new_position;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  position;
        logic                     click_cw;
        logic                     click_acw;
    } out_item_t;

endpackage

[rtl/core/qdc_if.sv]
`timescale 1ns / 1ps

// Sample channel.
interface qdc_in_if;
    logic              valid;
    logic              ready;
    qdc_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface qdc_out_if;
    logic               valid;
    logic               ready;
    qdc_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel for steps_per_click.
interface qdc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [qdc_pkg::STEPS_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/qdc_in_stage.sv]
`timescale 1ns / 1ps

module qdc_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qdc_pkg::in_item_t  in_data,
    input  logic               advance,
    output logic               item_valid,
    output qdc_pkg::in_item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    qdc_pkg::in_item_t item_reg;

    // Take a new sample when empty or when the held one moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

endmodule

[rtl/core/qdc_core.sv]
`timescale 1ns / 1ps

module qdc_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [qdc_pkg::STEPS_W-1:0]   cfg_data,
    input  logic                          take,
    input  qdc_pkg::in_item_t             item,
    output qdc_pkg::out_item_t            result
);

    logic [qdc_pkg::STEPS_W-1:0]        steps_reg;
    logic                               last_a_reg;
    logic                               last_a_next;
    logic                               last_b_reg;
    logic                               last_b_next;
    qdc_pkg::phase_t                    phase_reg;
    qdc_pkg::phase_t                    phase_next;
    qdc_pkg::phase_t                    dir_reg;
    qdc_pkg::phase_t                    dir_next;
    logic [qdc_pkg::STEPS_W-1:0]        run_reg;
    logic [qdc_pkg::STEPS_W-1:0]        run_next;
    logic signed [qdc_pkg::POS_W-1:0]   pos_reg;
    logic signed [qdc_pkg::POS_W-1:0]   pos_next;
    logic [qdc_pkg::STEPS_W-1:0]        run_bump;
    logic                               click_cw;
    logic                               click_acw;

    always_comb
    begin
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        phase_next  = phase_reg;
        dir_next    = dir_reg;
        run_next    = run_reg;
        pos_next    = pos_reg;
        click_cw    = 1'b0;
        click_acw   = 1'b0;
        run_bump    = (phase_reg == dir_reg) ? run_reg + 8'd1 : 8'd1;

        case (item.func)
            qdc_pkg::FUNC_SAMPLE:
            begin
                if (phase_reg == qdc_pkg::PH_STILL)
                begin
                    // A lone edge on A starts anticlockwise, on B clockwise.
                    if (item.chan_a != last_a_reg && item.chan_b == last_b_reg)
                    begin
                        last_a_next = item.chan_a;
                        phase_next  = qdc_pkg::PH_ACW;
                    end
                    else if (item.chan_a == last_a_reg && item.chan_b != last_b_reg)
                    begin
                        last_b_next = item.chan_b;
                        phase_next  = qdc_pkg::PH_CW;
                    end
                end
                else if (item.chan_a == item.chan_b)
                begin
                    // Movement done: count it and fire a click at threshold.
                    last_a_next = item.chan_a;
                    last_b_next = item.chan_b;
                    run_next    = run_bump;
                    if (run_bump >= steps_reg)
                    begin
                        run_next = '0;
                        if (phase_reg == qdc_pkg::PH_CW)
                        begin
                            click_cw = 1'b1;
                            pos_next = pos_reg + 32'sd1;
                        end
                        else if (phase_reg == qdc_pkg::PH_ACW)
                        begin
                            click_acw = 1'b1;
                            pos_next  = pos_reg - 32'sd1;
                        end
                    end
                    dir_next   = phase_reg;
                    phase_next = qdc_pkg::PH_STILL;
                end
            end
            qdc_pkg::FUNC_LOAD:
            begin
                pos_next = item.new_position;
            end
            qdc_pkg::FUNC_CLEAR:
            begin
                phase_next = qdc_pkg::PH_STILL;
                dir_next   = qdc_pkg::PH_STILL;
                run_next   = '0;
            end
            default:
            begin
                // Unused code: hold everything.
            end
        endcase
    end

    assign result.position  = pos_next;
    assign result.click_cw  = click_cw;
    assign result.click_acw = click_acw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg  <= qdc_pkg::STEPS_RESET;
            last_a_reg <= 1'b1;
            last_b_reg <= 1'b1;
            phase_reg  <= qdc_pkg::PH_STILL;
            dir_reg    <= qdc_pkg::PH_STILL;
            run_reg    <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                steps_reg <= cfg_data;
            end
            if (take)
            begin
                last_a_reg <= last_a_next;
                last_b_reg <= last_b_next;
                phase_reg  <= phase_next;
                dir_reg    <= dir_next;
                run_reg    <= run_next;
                pos_reg    <= pos_next;
            end
        end
    end

endmodule

[rtl/core/qdc_out_stage.sv]
`timescale 1ns / 1ps

module qdc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  qdc_pkg::out_item_t  result,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output qdc_pkg::out_item_t  out_data
);

    logic               valid_reg;
    logic               valid_next;
    qdc_pkg::out_item_t data_reg;

    // Load when empty or when the held result is taken this cycle.
    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            data_reg <= result;
        end
    end

endmodule

[rtl/core/quadrature_detent_counter.sv]
`timescale 1ns / 1ps

// Rotary encoder decoder with detent counting.
// Channels:
//   sample - one transfer per encoder sample (func, chan_a, chan_b, new_position).
//            func selects sample channels, load position or clear phase, direction and run count.
//   result - one transfer per sample: position after the item and click flags.
//   cfg    - write steps_per_click; always ready, write only while idle.
// Structure: a sample passes the input register, the decode logic and the result register,
// i.e. one register stage on each side of the decode logic.
// Throughput: one sample per cycle while result is not held off; the decode and the 32-bit increment
// fit between the input register and the result register.
// Reset: rst_n clears both stage valids, sets the channel history to the
// pull-up level (A=B=1), the phase and direction to still, the run count and
// position to zero and steps_per_click to 1.
// Stall: while result is held off, the result register keeps its transfer,
// the input register holds one more sample, and sample.ready drops once both
// are full. No transfer is lost or repeated.
module quadrature_detent_counter (
    input  logic       clk,
    input  logic       rst_n,
    qdc_in_if.sink     sample,
    qdc_out_if.source  result,
    qdc_cfg_if.sink    cfg
);

    logic               advance;
    logic               item_valid;
    qdc_pkg::in_item_t  item;
    qdc_pkg::out_item_t step_result;

    // Config register has no backpressure.
    assign cfg.ready = 1'b1;

    // Input register: holds one accepted sample.
    qdc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .in_data    (sample.data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Decode and state update; state commits only when the item moves on.
    qdc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.data),
        .take      (item_valid && advance),
        .item      (item),
        .result    (step_result)
    );

    // Result register: holds the result during a downstream stall; its advance also gates the input register.
    qdc_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (step_result),
        .advance    (advance),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (result.data)
    );

endmodule

[rtl/core/qdc_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qdc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         r_valid,
    input  logic                         r_ready,
    input  logic [qdc_pkg::POS_W-1:0]    r_position,
    input  logic                         r_click_cw,
    input  logic                         r_click_acw
);

    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       s_xfer;
    logic       r_xfer;

    assign s_xfer = s_valid && s_ready;
    assign r_xfer = r_valid && r_ready;

    // Track samples accepted but not yet delivered.
    always_comb
    begin
        occ_next = occ_reg;
        if (s_xfer && !r_xfer)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (!s_xfer && r_xfer)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `QDC_ASSERT(a_one_click, clk, rst_n, !(r_valid && r_click_cw && r_click_acw))
    `QDC_ASSERT_NEXT(a_hold, clk, rst_n, r_valid && !r_ready, r_valid && $stable(r_position) && $stable(r_click_cw) && $stable(r_click_acw))
    `QDC_ASSERT(a_no_invent, clk, rst_n, !r_valid || (occ_reg != 2'd0))
    `QDC_ASSERT(a_full_stall, clk, rst_n, !(occ_reg == 2'd2 && !r_ready && s_ready))

endmodule

bind quadrature_detent_counter qdc_checker u_qdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .s_valid     (sample.valid),
    .s_ready     (sample.ready),
    .r_valid     (result.valid),
    .r_ready     (result.ready),
    .r_position  (result.data.position),
    .r_click_cw  (result.data.click_cw),
    .r_click_acw (result.data.click_acw)
);
